/* rtl/ucre_pkg.sv */
// Shared types, codes and descriptor table for the USB control request engine.
package ucre_pkg;

  localparam int CONTROL_PACKET_BYTES = 16;
  localparam int DESCRIPTOR_ENTRIES   = 6;
  localparam int TABLE_SIZE           = 6;
  localparam int MAX_RESULTS          = 16;
  localparam int DESC_SEARCH =
    (DESCRIPTOR_ENTRIES < TABLE_SIZE) ? DESCRIPTOR_ENTRIES : TABLE_SIZE;
  localparam int PKT_W = $clog2(CONTROL_PACKET_BYTES + 1);
  localparam int K_W   = $clog2(MAX_RESULTS);
  localparam int ADDR_W = 4;

  localparam logic [K_W-1:0]   LAST_K   = K_W'(MAX_RESULTS - 1);
  localparam logic [PKT_W-1:0] PKT_FULL = PKT_W'(CONTROL_PACKET_BYTES);

  typedef enum logic [2:0] {
    OP_SETUP     = 3'd0,
    OP_SOF       = 3'd1,
    OP_BUS_RESET = 3'd2,
    OP_TX_BYTE   = 3'd3,
    OP_FLUSH     = 3'd4
  } opcode_t;

  typedef enum logic [3:0] {
    ACT_STALL        = 4'd0,
    ACT_DESC_PACKET  = 4'd1,
    ACT_SET_ADDRESS  = 4'd2,
    ACT_SET_CONFIG   = 4'd3,
    ACT_SEND_CONFIG  = 4'd4,
    ACT_SEND_LINE    = 4'd5,
    ACT_RECV_LINE    = 4'd6,
    ACT_LINES_ACK    = 4'd7,
    ACT_STATUS_ZERO  = 4'd8,
    ACT_RELEASE_BANK = 4'd9
  } action_t;

  localparam logic [7:0] REQ_GET_STATUS      = 8'h00;
  localparam logic [7:0] REQ_SET_ADDRESS     = 8'h05;
  localparam logic [7:0] REQ_GET_DESCRIPTOR  = 8'h06;
  localparam logic [7:0] REQ_GET_CONFIG      = 8'h08;
  localparam logic [7:0] REQ_SET_CONFIG      = 8'h09;
  localparam logic [7:0] REQ_SET_LINE_CODING = 8'h20;
  localparam logic [7:0] REQ_GET_LINE_CODING = 8'h21;
  localparam logic [7:0] REQ_SET_CTRL_LINES  = 8'h22;

  localparam logic [7:0] TYPE_STD_OUT   = 8'h00;
  localparam logic [7:0] TYPE_STD_IN    = 8'h80;
  localparam logic [7:0] TYPE_CLASS_IN  = 8'ha1;
  localparam logic [7:0] TYPE_CLASS_OUT = 8'h21;

  localparam logic [1:0] REG_FLUSH_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_MANUF_LEN     = 2'd1;
  localparam logic [1:0] REG_PRODUCT_LEN   = 2'd2;
  localparam logic [1:0] REG_SERIAL_LEN    = 2'd3;

  localparam logic [7:0] DEVICE_DESC_LEN = 8'd18;
  localparam logic [7:0] CONFIG_DESC_LEN = 8'd67;
  localparam logic [7:0] LANG_DESC_LEN   = 8'd4;
  localparam logic [7:0] MAX_XFER_LEN    = 8'd255;

  localparam logic [15:0] DESC_VALUE [TABLE_SIZE] =
    '{16'h0100, 16'h0200, 16'h0300, 16'h0301, 16'h0302, 16'h0303};
  localparam logic [15:0] DESC_INDEX [TABLE_SIZE] =
    '{16'h0000, 16'h0000, 16'h0000, 16'h0409, 16'h0409, 16'h0409};

  typedef struct packed {
    logic load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic has_result;
    logic fin;
  } status_t;

endpackage

/* rtl/ucre_ctrl.sv */
// Controller state machine: accepts requests and sequences result transfers.
module ucre_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  ucre_pkg::status_t status,
  output ucre_pkg::cmd_t   cmd
);
  import ucre_pkg::*;

  typedef enum logic {
    IDLE,
    EMIT
  } state_t;

  state_t state;

  assign in_stall = (state != IDLE);
  assign cmd.load = in_valid && (state == IDLE);
  assign cmd.emit = (state == EMIT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (cmd.load && status.has_result) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (cmd.emit && status.fin) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && !status.fin |=> state == EMIT)
    else $error("packet run ended early");

  a_no_result_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load && !status.has_result |=> state == IDLE && $stable(out_valid) || !out_valid)
    else $error("item without result started a run");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

endmodule

/* rtl/ucre_dp.sv */
// Datapath: registers, request decode, packet run arithmetic and result register.
module ucre_dp (
  input  logic              clk,
  input  logic              rst,
  input  ucre_pkg::cmd_t    cmd,
  output ucre_pkg::status_t status,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ucre_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic [2:0]        opcode,
  input  logic [7:0]        request_type,
  input  logic [7:0]        request_code,
  input  logic [15:0]       request_value,
  input  logic [15:0]       request_index,
  input  logic [15:0]       request_length,
  output logic [3:0]        action,
  output logic [2:0]        descriptor_select,
  output logic [7:0]        packet_offset,
  output logic [4:0]        packet_bytes,
  output logic [6:0]        device_address,
  output logic [7:0]        config_value,
  output logic [7:0]        control_lines,
  output logic              last
);
  import ucre_pkg::*;

  logic [7:0] flush_timeout;
  logic [7:0] manuf_len;
  logic [7:0] product_len;
  logic [7:0] serial_len;
  logic [7:0] configuration;
  logic [7:0] line_control;
  logic [7:0] flush_countdown;

  action_t        act_q;
  logic [2:0]     sel_q;
  logic [6:0]     addr_q;
  logic [7:0]     rem_q;
  logic [7:0]     off_q;
  logic [K_W-1:0] k_q;
  logic           is_desc_q;

  logic       hit;
  logic [2:0] found;
  logic [7:0] entry_len;
  logic [7:0] req_len;
  logic [7:0] run_len;
  action_t    act_d;
  logic       has_res;

  logic [PKT_W-1:0] pkt_n;
  logic [7:0]       rem_next;
  logic             fin;

  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_FLUSH_TIMEOUT: prdata = {24'd0, flush_timeout};
      REG_MANUF_LEN:     prdata = {24'd0, manuf_len};
      REG_PRODUCT_LEN:   prdata = {24'd0, product_len};
      REG_SERIAL_LEN:    prdata = {24'd0, serial_len};
      default:           prdata = 32'd0;
    endcase
  end

  always_comb begin
    hit   = 1'b0;
    found = 3'd0;
    for (int e = DESC_SEARCH - 1; e >= 0; e--) begin
      if (DESC_VALUE[e] == request_value && DESC_INDEX[e] == request_index) begin
        hit   = 1'b1;
        found = 3'(e);
      end
    end
  end

  always_comb begin
    unique case (found)
      3'd0:    entry_len = DEVICE_DESC_LEN;
      3'd1:    entry_len = CONFIG_DESC_LEN;
      3'd2:    entry_len = LANG_DESC_LEN;
      3'd3:    entry_len = manuf_len;
      3'd4:    entry_len = product_len;
      default: entry_len = serial_len;
    endcase
    req_len = (request_length[15:8] != 8'd0) ? MAX_XFER_LEN : request_length[7:0];
    run_len = (req_len > entry_len) ? entry_len : req_len;
  end

  always_comb begin
    act_d   = ACT_STALL;
    has_res = 1'b0;
    unique case (opcode)
      OP_SETUP: begin
        has_res = 1'b1;
        if (request_code == REQ_GET_DESCRIPTOR) begin
          act_d = hit ? ACT_DESC_PACKET : ACT_STALL;
        end else if (request_code == REQ_SET_ADDRESS) begin
          act_d = ACT_SET_ADDRESS;
        end else if (request_code == REQ_SET_CONFIG && request_type == TYPE_STD_OUT) begin
          act_d = ACT_SET_CONFIG;
        end else if (request_code == REQ_GET_CONFIG && request_type == TYPE_STD_IN) begin
          act_d = ACT_SEND_CONFIG;
        end else if (request_code == REQ_GET_LINE_CODING && request_type == TYPE_CLASS_IN) begin
          act_d = ACT_SEND_LINE;
        end else if (request_code == REQ_SET_LINE_CODING && request_type == TYPE_CLASS_OUT) begin
          act_d = ACT_RECV_LINE;
        end else if (request_code == REQ_SET_CTRL_LINES && request_type == TYPE_CLASS_OUT) begin
          act_d = ACT_LINES_ACK;
        end else if (request_code == REQ_GET_STATUS) begin
          act_d = ACT_STATUS_ZERO;
        end
      end
      OP_SOF: begin
        act_d   = ACT_RELEASE_BANK;
        has_res = (configuration != 8'd0) && (flush_countdown == 8'd1);
      end
      OP_FLUSH: begin
        act_d   = ACT_RELEASE_BANK;
        has_res = (flush_countdown != 8'd0);
      end
      default: begin
        act_d   = ACT_STALL;
        has_res = 1'b0;
      end
    endcase
  end

  assign status.has_result = has_res;

  assign pkt_n    = (rem_q < 8'(CONTROL_PACKET_BYTES)) ? PKT_W'(rem_q) : PKT_FULL;
  assign rem_next = rem_q - 8'(pkt_n);
  assign fin      = !is_desc_q || (rem_next == 8'd0 && pkt_n != PKT_FULL) || k_q == LAST_K;
  assign status.fin = fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      flush_timeout   <= 8'd5;
      manuf_len       <= 8'd2;
      product_len     <= 8'd2;
      serial_len      <= 8'd2;
      configuration   <= 8'd0;
      line_control    <= 8'd0;
      flush_countdown <= 8'd0;
    end else begin
      if (cfg_write) begin
        unique case (paddr[3:2])
          REG_FLUSH_TIMEOUT: flush_timeout <= pwdata[7:0];
          REG_MANUF_LEN:     manuf_len     <= pwdata[7:0];
          REG_PRODUCT_LEN:   product_len   <= pwdata[7:0];
          REG_SERIAL_LEN:    serial_len    <= pwdata[7:0];
          default:           flush_timeout <= flush_timeout;
        endcase
      end
      if (cmd.load) begin
        unique case (opcode)
          OP_SETUP: begin
            if (act_d == ACT_SET_CONFIG) begin
              configuration   <= request_value[7:0];
              line_control    <= 8'd0;
              flush_countdown <= 8'd0;
            end else if (act_d == ACT_LINES_ACK) begin
              line_control <= request_value[7:0];
            end
          end
          OP_SOF: begin
            if (configuration != 8'd0 && flush_countdown != 8'd0) begin
              flush_countdown <= flush_countdown - 8'd1;
            end
          end
          OP_BUS_RESET: begin
            configuration <= 8'd0;
            line_control  <= 8'd0;
          end
          OP_TX_BYTE: begin
            if (configuration != 8'd0) begin
              flush_countdown <= flush_timeout;
            end
          end
          OP_FLUSH: flush_countdown <= 8'd0;
          default:  flush_countdown <= flush_countdown;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q     <= act_d;
      is_desc_q <= (act_d == ACT_DESC_PACKET);
      sel_q     <= (act_d == ACT_DESC_PACKET) ? found : 3'd0;
      rem_q     <= (act_d == ACT_DESC_PACKET) ? run_len : 8'd0;
      addr_q    <= (act_d == ACT_SET_ADDRESS) ? request_value[6:0] : 7'd0;
      off_q     <= 8'd0;
      k_q       <= '0;
    end else if (cmd.emit) begin
      rem_q <= rem_next;
      off_q <= off_q + 8'(pkt_n);
      k_q   <= k_q + K_W'(1);
    end
    if (cmd.emit) begin
      action            <= act_q;
      descriptor_select <= sel_q;
      packet_offset     <= off_q;
      packet_bytes      <= 5'(pkt_n);
      device_address    <= addr_q;
      config_value      <= configuration;
      control_lines     <= line_control;
      last              <= fin;
    end
  end

  a_pkt_size: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> packet_bytes <= 5'(CONTROL_PACKET_BYTES))
    else $error("packet larger than control endpoint size");

endmodule

/* rtl/usb_control_request_engine.sv */
// Top level of the USB control request engine for a CDC serial device.
//
//   channel   handshake             contents
//   in        in_valid / in_stall   opcode and SETUP packet words
//   out       out_valid / out_stall action, descriptor packet, address, state
//   config    APB psel/penable      flush timeout and string lengths
//
// An item is taken while in_stall is low; each result is then loaded into the
// output register when it is free, one per descriptor packet, up to 16 packets.
// Items without results finish in the acceptance cycle. The output register
// lets a new item enter while the last result waits. Reset is synchronous and
// restores the register defaults and clears configuration, lines and timer.
module usb_control_request_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [ucre_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [7:0]  request_type,
  input  logic [7:0]  request_code,
  input  logic [15:0] request_value,
  input  logic [15:0] request_index,
  input  logic [15:0] request_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  action,
  output logic [2:0]  descriptor_select,
  output logic [7:0]  packet_offset,
  output logic [4:0]  packet_bytes,
  output logic [6:0]  device_address,
  output logic [7:0]  config_value,
  output logic [7:0]  control_lines,
  output logic        last
);
  import ucre_pkg::*;

  cmd_t    cmd;
  status_t status;

  ucre_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ucre_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .opcode            (opcode),
    .request_type      (request_type),
    .request_code      (request_code),
    .request_value     (request_value),
    .request_index     (request_index),
    .request_length    (request_length),
    .action            (action),
    .descriptor_select (descriptor_select),
    .packet_offset     (packet_offset),
    .packet_bytes      (packet_bytes),
    .device_address    (device_address),
    .config_value      (config_value),
    .control_lines     (control_lines),
    .last              (last)
  );

endmodule
